[rtl/x86_partial_register_file_assert.svh]
// Assertion macros used by the register file checker.
// Needs signals clock and reset in the scope where the macros are used.
`ifndef X86_PARTIAL_REGISTER_FILE_ASSERT_SVH
`define X86_PARTIAL_REGISTER_FILE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define XPRF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define XPRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/xprf_pkg.sv]
// Shared types and constants for the x86 partial register file.
// No dependencies.
`default_nettype none

package xprf_pkg;

   localparam int XPRF_GP_COUNT  = 8;
   localparam int XPRF_ENTRY_W   = $clog2(XPRF_GP_COUNT);
   localparam int XPRF_DATA_W    = 32;

   localparam logic [1:0] OP_READ_ZX = 2'd0;
   localparam logic [1:0] OP_READ_SX = 2'd1;
   localparam logic [1:0] OP_WRITE   = 2'd2;
   localparam logic [1:0] OP_NOP     = 2'd3;

   localparam logic [1:0] SIZE_BYTE  = 2'd0;
   localparam logic [1:0] SIZE_WORD  = 2'd1;
   localparam logic [1:0] SIZE_DWORD = 2'd2;
   localparam logic [1:0] SIZE_BAD   = 2'd3;

   localparam logic [3:0] IDX_HIGH_BASE = 4'd8;
   localparam logic [3:0] IDX_LIMIT     = 4'd12;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [3:0]  reg_index;
      logic [1:0]  size_code;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        access_error;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/xprf_ram.sv]
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none

module xprf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/x86_partial_register_file.sv]
// Top level of the x86 partial register file: decode, read-modify-write, result register.
// Depends on xprf_pkg and xprf_ram.
//
//   channel  | dir | handshake             | payload
//   req_     | in  | req_valid / req_ready | req_payload (req_type)
//   rsp_     | out | rsp_valid / rsp_ready | rsp_payload (rsp_type)
//
// Each transfer is handled as the RAM read, then extend / merge and write-back.
// A new request is taken once the previous one has left the execute cycle.
// The execute cycle stalls while an unconsumed result sits in the output register.
// Reset clears the entry valid bits, so every register reads as zero until written.
`default_nettype none

module x86_partial_register_file
   import xprf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_payload,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_payload
);

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   state_type                  state_ff, state_in;
   logic [XPRF_GP_COUNT-1:0]   gp_valid_ff, gp_valid_in;
   logic [1:0]                 op_ff, op_in;
   logic [1:0]                 size_ff, size_in;
   logic                       high_ff, high_in;
   logic                       err_ff, err_in;
   logic [XPRF_ENTRY_W-1:0]    entry_ff, entry_in;
   logic [XPRF_DATA_W-1:0]     wdata_ff, wdata_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;

   logic                       accept;
   logic                       fire;
   logic                       sgn;
   logic [XPRF_DATA_W-1:0]     ram_rd_data;
   logic [XPRF_DATA_W-1:0]     cur;
   logic [7:0]                 byte_src;
   logic [XPRF_DATA_W-1:0]     rd_val;
   logic [XPRF_DATA_W-1:0]     merged;
   logic                       wr_en;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign fire        = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // request decode
   always_comb begin
      op_in    = op_ff;
      size_in  = size_ff;
      high_in  = high_ff;
      err_in   = err_ff;
      entry_in = entry_ff;
      wdata_in = wdata_ff;
      if (accept) begin
         op_in    = req_payload.opcode;
         size_in  = req_payload.size_code;
         high_in  = req_payload.reg_index[3];
         err_in   = (req_payload.opcode != OP_NOP) &&
                    ((req_payload.size_code == SIZE_BAD) ||
                     (req_payload.reg_index >= IDX_LIMIT) ||
                     ((req_payload.reg_index >= IDX_HIGH_BASE) &&
                      (req_payload.size_code != SIZE_BYTE)));
         entry_in = req_payload.reg_index[3] ?
                    XPRF_ENTRY_W'(req_payload.reg_index[1:0]) :
                    req_payload.reg_index[XPRF_ENTRY_W-1:0];
         wdata_in = req_payload.write_data;
      end
   end

   // extend and merge
   always_comb begin
      cur      = gp_valid_ff[entry_ff] ? ram_rd_data : '0;
      sgn      = (op_ff == OP_READ_SX);
      byte_src = high_ff ? cur[15:8] : cur[7:0];
      case (size_ff)
         SIZE_BYTE: rd_val = {{24{sgn & byte_src[7]}}, byte_src};
         SIZE_WORD: rd_val = {{16{sgn & cur[15]}}, cur[15:0]};
         default:   rd_val = cur;
      endcase
      if (high_ff) begin
         merged = {cur[31:16], wdata_ff[7:0], cur[7:0]};
      end else begin
         case (size_ff)
            SIZE_BYTE: merged = {cur[31:8], wdata_ff[7:0]};
            SIZE_WORD: merged = {cur[31:16], wdata_ff[15:0]};
            default:   merged = wdata_ff;
         endcase
      end
      wr_en = fire && (op_ff == OP_WRITE) && !err_ff;
   end

   // control and result register
   always_comb begin
      state_in     = state_ff;
      gp_valid_in  = gp_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in.access_error = err_ff;
               rsp_in.read_data    = (!err_ff && ((op_ff == OP_READ_ZX) ||
                                                  (op_ff == OP_READ_SX))) ? rd_val : '0;
               if (wr_en) begin
                  gp_valid_in[entry_ff] = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gp_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gp_valid_ff  <= gp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff    <= op_in;
      size_ff  <= size_in;
      high_ff  <= high_in;
      err_ff   <= err_in;
      entry_ff <= entry_in;
      wdata_ff <= wdata_in;
      rsp_ff   <= rsp_in;
   end

   xprf_ram #(
      .WIDTH (XPRF_DATA_W),
      .DEPTH (XPRF_GP_COUNT)
   ) u_gp_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (entry_ff),
      .wr_data (merged),
      .rd_en   (accept),
      .rd_addr (entry_in),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

[rtl/xprf_checker.sv]
// Port-level checks for the x86 partial register file, bound to the top level.
// Depends on xprf_pkg and x86_partial_register_file_assert.svh.
`default_nettype none

`include "x86_partial_register_file_assert.svh"

module xprf_checker
   import xprf_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_payload,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_payload
);

   logic req_wait;
   logic rsp_wait;
   logic req_fire;
   logic rsp_err;

   assign req_wait = req_valid && !req_ready;
   assign rsp_wait = rsp_valid && !rsp_ready;
   assign req_fire = req_valid && req_ready;
   assign rsp_err  = rsp_valid && rsp_payload.access_error;

   `XPRF_ASSERT_NEXT(a_req_hold, req_wait, req_valid && $stable(req_payload), "request dropped")
   `XPRF_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp_payload), "result dropped")
   `XPRF_ASSERT_NOW(a_err_zero, rsp_err, rsp_payload.read_data == 32'd0, "error with data")
   `XPRF_ASSERT_NEXT(a_one_in_flight, req_fire, !req_ready, "second request taken")
   `XPRF_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid, "result present after reset")

endmodule

bind x86_partial_register_file xprf_checker u_xprf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

[tb/sv/x86_partial_register_file_tb.sv]
// Self-checking bench for x86_partial_register_file: directed and random register accesses,
// with random gaps and stalls on both channels and a long result hold-off.
// Depends on xprf_pkg and the register file RTL.
`timescale 1ns / 1ps

module x86_partial_register_file_tb;
   import xprf_pkg::*;

   localparam int RANDOM_ACCESSES = 1100;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_LENGTH     = 100;
   localparam int DRAIN_CYCLES    = 10;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   req_type     pending_req [$];
   rsp_type     expected_rsp [$];
   logic [31:0] gpr_shadow [XPRF_GP_COUNT];

   int   total_items   = 0;
   int   req_count     = 0;
   int   rsp_count     = 0;
   int   mismatch_count = 0;
   int   idle_cycles   = 0;
   int   tx_gap        = 0;
   int   rx_stall      = 0;
   int   hold_cycles   = 0;
   int   next_hold_at  = 300;
   logic req_taken     = 1'b0;
   logic tx_calm       = 1'b0;
   logic rx_calm       = 1'b0;

   x86_partial_register_file dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic req_type make_access(input logic [1:0] op, input logic [3:0] idx,
                                           input logic [1:0] sz, input logic [31:0] data);
      req_type a;
      a.opcode     = op;
      a.reg_index  = idx;
      a.size_code  = sz;
      a.write_data = data;
      return a;
   endfunction

   function automatic int idle_length(input logic calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm)
         return 0;
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Applies one access to the shadow registers and returns the result it should give.
   function automatic rsp_type predict_access(input req_type a);
      rsp_type     res;
      logic [31:0] v;
      logic [31:0] mask;
      logic [2:0]  ent;
      logic        sx;
      res = '0;
      sx  = (a.opcode == OP_READ_SX);
      if (a.opcode == OP_NOP)
         return res;
      if (a.size_code == SIZE_BAD || a.reg_index >= IDX_LIMIT ||
          (a.reg_index >= IDX_HIGH_BASE && a.size_code != SIZE_BYTE)) begin
         res.access_error = 1'b1;
         return res;
      end
      if (a.reg_index >= IDX_HIGH_BASE) begin
         ent = {1'b0, a.reg_index[1:0]};
         v   = gpr_shadow[ent];
         if (a.opcode == OP_WRITE)
            gpr_shadow[ent][15:8] = a.write_data[7:0];
         else
            res.read_data = sx ? {{24{v[15]}}, v[15:8]} : {24'h0, v[15:8]};
         return res;
      end
      ent = a.reg_index[2:0];
      v   = gpr_shadow[ent];
      case (a.size_code)
         SIZE_BYTE: mask = 32'h0000_00ff;
         SIZE_WORD: mask = 32'h0000_ffff;
         default:   mask = 32'hffff_ffff;
      endcase
      if (a.opcode == OP_WRITE) begin
         gpr_shadow[ent] = (v & ~mask) | (a.write_data & mask);
      end else begin
         case (a.size_code)
            SIZE_BYTE: res.read_data = sx ? {{24{v[7]}}, v[7:0]} : {24'h0, v[7:0]};
            SIZE_WORD: res.read_data = sx ? {{16{v[15]}}, v[15:0]} : {16'h0, v[15:0]};
            default:   res.read_data = v;
         endcase
      end
      return res;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // transfer still pending, hold payload
      end else if (tx_gap != 0) begin
         tx_gap    <= tx_gap - 1;
         req_valid <= 1'b0;
      end else if (pending_req.size() != 0) begin
         req_payload <= pending_req.pop_front();
         req_valid   <= 1'b1;
         tx_gap      <= idle_length(tx_calm);
         if ($urandom_range(0, 63) == 0)
            tx_calm <= !tx_calm;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles != 0) begin
         rsp_ready <= 1'b0;
      end else if (rx_stall != 0) begin
         rx_stall  <= rx_stall - 1;
         rsp_ready <= 1'b0;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
         rx_stall  <= idle_length(1'b0);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
      if (!reset && $urandom_range(0, 199) == 0)
         rx_calm <= !rx_calm;
   end

   // long hold-off so the block fills and back-pressures the sender
   always @(negedge clock) begin
      if (reset)
         hold_cycles <= 0;
      else if (hold_cycles != 0)
         hold_cycles <= hold_cycles - 1;
      else if (req_count >= next_hold_at) begin
         hold_cycles  <= HOLD_LENGTH;
         next_hold_at <= next_hold_at + 500;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
         foreach (gpr_shadow[i])
            gpr_shadow[i] = '0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            expected_rsp.push_back(predict_access(req_payload));
            req_count <= req_count + 1;
         end
         if (rsp_valid && rsp_ready) begin
            got       = rsp_payload;
            rsp_count <= rsp_count + 1;
            if (expected_rsp.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected result read_data=%h access_error=%b",
                           $realtime, got.read_data, got.access_error);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_rsp.pop_front();
               if (got.read_data !== want.read_data ||
                   got.access_error !== want.access_error) begin
                  if (mismatch_count < 10)
                     $display("%0t: result %0d mismatch: read_data exp %h got %h, access_error exp %b got %b",
                              $realtime, rsp_count, want.read_data, got.read_data,
                              want.access_error, got.access_error);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      req_type a;
      int      pick;
      // reset values, extension sign bits and partial merges
      pending_req.push_back(make_access(OP_READ_ZX, 4'd7, SIZE_DWORD, 32'h0));
      pending_req.push_back(make_access(OP_WRITE, 4'd0, SIZE_DWORD, 32'hffff_ffff));
      pending_req.push_back(make_access(OP_WRITE, 4'd0, SIZE_BYTE, 32'h0000_0080));
      pending_req.push_back(make_access(OP_READ_SX, 4'd0, SIZE_BYTE, 32'h0));
      pending_req.push_back(make_access(OP_READ_ZX, 4'd0, SIZE_BYTE, 32'h0));
      pending_req.push_back(make_access(OP_WRITE, 4'd0, SIZE_WORD, 32'h5a5a_8000));
      pending_req.push_back(make_access(OP_READ_SX, 4'd0, SIZE_WORD, 32'h0));
      pending_req.push_back(make_access(OP_READ_ZX, 4'd0, SIZE_WORD, 32'h0));
      // high bytes
      pending_req.push_back(make_access(OP_WRITE, 4'd8, SIZE_BYTE, 32'hffff_ffa5));
      pending_req.push_back(make_access(OP_READ_SX, 4'd8, SIZE_BYTE, 32'h0));
      pending_req.push_back(make_access(OP_READ_ZX, 4'd8, SIZE_BYTE, 32'h0));
      pending_req.push_back(make_access(OP_WRITE, 4'd11, SIZE_BYTE, 32'h0000_007f));
      pending_req.push_back(make_access(OP_READ_SX, 4'd11, SIZE_BYTE, 32'h0));
      pending_req.push_back(make_access(OP_READ_ZX, 4'd3, SIZE_DWORD, 32'h0));
      // refused accesses and no-op
      pending_req.push_back(make_access(OP_WRITE, 4'd9, SIZE_WORD, 32'hffff_ffff));
      pending_req.push_back(make_access(OP_READ_ZX, 4'd10, SIZE_DWORD, 32'h0));
      pending_req.push_back(make_access(OP_WRITE, 4'd12, SIZE_BYTE, 32'hffff_ffff));
      pending_req.push_back(make_access(OP_READ_SX, 4'd15, SIZE_DWORD, 32'h0));
      pending_req.push_back(make_access(OP_WRITE, 4'd7, SIZE_BAD, 32'hffff_ffff));
      pending_req.push_back(make_access(OP_NOP, 4'd15, SIZE_BAD, 32'hffff_ffff));
      pending_req.push_back(make_access(OP_WRITE, 4'd7, SIZE_DWORD, 32'h8000_0000));
      pending_req.push_back(make_access(OP_READ_SX, 4'd7, SIZE_DWORD, 32'h0));
      pending_req.push_back(make_access(OP_READ_ZX, 4'd7, SIZE_BYTE, 32'h0));
      pending_req.push_back(make_access(OP_WRITE, 4'd4, SIZE_DWORD, 32'h0));
      pending_req.push_back(make_access(OP_READ_SX, 4'd9, SIZE_BYTE, 32'h0));

      repeat (RANDOM_ACCESSES) begin
         pick = $urandom_range(0, 99);
         if (pick < 38)
            a.opcode = OP_WRITE;
         else if (pick < 64)
            a.opcode = OP_READ_ZX;
         else if (pick < 94)
            a.opcode = OP_READ_SX;
         else
            a.opcode = OP_NOP;
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            a.reg_index = 4'($urandom_range(12, 15));
            a.size_code = 2'($urandom_range(0, 3));
         end else if (pick == 1) begin
            a.reg_index = 4'($urandom_range(0, 15));
            a.size_code = SIZE_BAD;
         end else if (pick == 2) begin
            a.reg_index = 4'($urandom_range(8, 11));
            a.size_code = 2'($urandom_range(1, 3));
         end else begin
            a.reg_index = 4'($urandom_range(0, 11));
            a.size_code = (a.reg_index >= IDX_HIGH_BASE) ? SIZE_BYTE
                                                         : 2'($urandom_range(0, 2));
         end
         case ($urandom_range(0, 15))
            0:       a.write_data = 32'h0;
            1:       a.write_data = 32'hffff_ffff;
            2:       a.write_data = 32'h0000_0080;
            3:       a.write_data = 32'h0000_8000;
            4:       a.write_data = 32'h8000_0000;
            default: a.write_data = $urandom;
         endcase
         pending_req.push_back(a);
      end
      total_items = pending_req.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (rsp_count != total_items)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
